FILE: hw/rtl/romc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romc_pkg
// Shared types, ROMC control codes, register indexes and byte helpers.
// ----------------------------------------------------------------------------
package romc_pkg;

   localparam int MEM_DEPTH_DEF = 4096;

   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 5;
   localparam int LOAD_W  = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int FLAG_W  = 4;

   typedef logic [CODE_W-1:0]    romc_code_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   typedef struct packed {
      logic          operation;
      romc_code_type romc_code;
      byte_type      bus_in;
      logic [LOAD_W-1:0] load_address;
      byte_type      load_data;
   } item_type;

   localparam logic OP_ROMC    = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   localparam csr_index_type CSR_WINDOW_START    = 3'd0;
   localparam csr_index_type CSR_WINDOW_END      = 3'd1;
   localparam csr_index_type CSR_WINDOW_ENABLED  = 3'd2;
   localparam csr_index_type CSR_MEMORY_WRITABLE = 3'd3;
   localparam csr_index_type CSR_ABSENT_REGS     = 3'd4;

   localparam addr_type WINDOW_END_RST = 16'h0FFF;

   localparam int NO_PC0 = 0;
   localparam int NO_PC1 = 1;
   localparam int NO_DC0 = 2;
   localparam int NO_DC1 = 3;

   localparam romc_code_type ROMC_FETCH_PC0          = 5'h00;
   localparam romc_code_type ROMC_BRANCH_PC0         = 5'h01;
   localparam romc_code_type ROMC_FETCH_DC0          = 5'h02;
   localparam romc_code_type ROMC_FETCH_PC0_ALT      = 5'h03;
   localparam romc_code_type ROMC_PC1_TO_PC0         = 5'h04;
   localparam romc_code_type ROMC_STORE_DC0          = 5'h05;
   localparam romc_code_type ROMC_DRIVE_DC0_HIGH     = 5'h06;
   localparam romc_code_type ROMC_DRIVE_PC1_HIGH     = 5'h07;
   localparam romc_code_type ROMC_CLEAR_PC0          = 5'h08;
   localparam romc_code_type ROMC_DRIVE_DC0_LOW      = 5'h09;
   localparam romc_code_type ROMC_ADD_DC0            = 5'h0A;
   localparam romc_code_type ROMC_DRIVE_PC1_LOW      = 5'h0B;
   localparam romc_code_type ROMC_MEM_PC0_LOW        = 5'h0C;
   localparam romc_code_type ROMC_PC0_INC_TO_PC1     = 5'h0D;
   localparam romc_code_type ROMC_MEM_DC0_LOW        = 5'h0E;
   localparam romc_code_type ROMC_VECTOR             = 5'h0F;
   localparam romc_code_type ROMC_MEM_DC0_HIGH       = 5'h11;
   localparam romc_code_type ROMC_CALL_LOW           = 5'h12;
   localparam romc_code_type ROMC_BUS_PC0_HIGH       = 5'h14;
   localparam romc_code_type ROMC_BUS_PC1_HIGH       = 5'h15;
   localparam romc_code_type ROMC_BUS_DC0_HIGH       = 5'h16;
   localparam romc_code_type ROMC_BUS_PC0_LOW        = 5'h17;
   localparam romc_code_type ROMC_BUS_PC1_LOW        = 5'h18;
   localparam romc_code_type ROMC_BUS_DC0_LOW        = 5'h19;
   localparam romc_code_type ROMC_SWAP_DC            = 5'h1D;
   localparam romc_code_type ROMC_DRIVE_PC0_LOW      = 5'h1E;
   localparam romc_code_type ROMC_DRIVE_PC0_HIGH     = 5'h1F;

   function automatic addr_type add_signed(addr_type r, byte_type b);
      addr_type ext;
      ext = {{(ADDR_W-BYTE_W){b[BYTE_W-1]}}, b};
      return addr_type'(r + ext);
   endfunction

   function automatic addr_type set_low(addr_type r, byte_type b);
      return {r[ADDR_W-1:BYTE_W], b};
   endfunction

   function automatic addr_type set_high(addr_type r, byte_type b);
      return {b, r[BYTE_W-1:0]};
   endfunction

endpackage

FILE: hw/rtl/romc_memory_interface_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romc_memory_interface_unit
// ROMC-driven memory interface: PC0/PC1/DC0/DC1 address registers and a byte
// memory mapped at a configurable window.
// ----------------------------------------------------------------------------
//  channel | ports  | beat
//  --------+--------+-----------------------------------------------------
//  input   | req_*  | one ROMC cycle or one preload byte
//  result  | rsp_*  | bus byte, drive flag, address registers after the beat
//  config  | csr_*  | one register write, no wait
//
//  One beat per cycle while rsp_ready holds; work stage, then result register.
//  The memory read issues at accept with the address after all earlier beats;
//  the update and any memory write happen when the beat moves to the result.
//  Result stall: one more beat is taken, then req_ready drops.
//  Reset clears the address registers and control; memory holds no reset.
// ----------------------------------------------------------------------------
module romc_memory_interface_unit #(
   parameter int MEM_DEPTH = romc_pkg::MEM_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  romc_pkg::romc_code_type     req_romc_code,
   input  romc_pkg::byte_type          req_bus_in,
   input  logic [romc_pkg::LOAD_W-1:0] req_load_address,
   input  romc_pkg::byte_type          req_load_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output romc_pkg::byte_type          rsp_bus_out,
   output logic                        rsp_drove_bus,
   output romc_pkg::addr_type          rsp_program_counter,
   output romc_pkg::addr_type          rsp_stack_register,
   output romc_pkg::addr_type          rsp_data_counter,
   output romc_pkg::addr_type          rsp_alternate_data_counter,
   input  logic                        csr_write_enable,
   input  romc_pkg::csr_index_type     csr_index,
   input  logic [romc_pkg::CSR_DAT_W-1:0] csr_write_data
);
   import romc_pkg::*;

   localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CMP_W = ADDR_W + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(MEM_DEPTH);

   // configuration
   addr_type          win_start_ff, win_end_ff;
   logic              win_en_ff, writable_ff;
   logic [FLAG_W-1:0] absent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= WINDOW_END_RST;
         win_en_ff    <= 1'b1;
         writable_ff  <= 1'b0;
         absent_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_START:    win_start_ff <= csr_write_data;
            CSR_WINDOW_END:      win_end_ff   <= csr_write_data;
            CSR_WINDOW_ENABLED:  win_en_ff    <= csr_write_data[0];
            CSR_MEMORY_WRITABLE: writable_ff  <= csr_write_data[0];
            CSR_ABSENT_REGS:     absent_ff    <= csr_write_data[FLAG_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic in_win(addr_type a, addr_type ws, addr_type we, logic en);
      return en && (a >= ws) && (a <= we);
   endfunction

   function automatic logic off_ok(addr_type a, addr_type ws);
      addr_type off;
      off = addr_type'(a - ws);
      return {1'b0, off} < DEPTH_C;
   endfunction

   // work stage and architectural registers
   item_type p_item_ff;
   logic     p_valid_ff;
   addr_type pc0_ff, pc1_ff, dc0_ff, dc1_ff;
   addr_type pc0_in, pc1_in, dc0_in, dc1_in;
   byte_type bus_in, rd_data_ff, byp_data_ff, md;
   logic     drove_in, byp_ff;
   logic     rsp_valid_ff, rsp_drove_ff;
   byte_type rsp_bus_ff;
   logic     commit, req_fire;
   logic     wr_en;
   logic [AW-1:0] wr_idx, rd_idx;
   byte_type wr_data;
   addr_type rd_addr, rd_off, wr_off;
   logic [CMP_W-1:0] la_ext;

   byte_type mem [MEM_DEPTH];

   assign commit    = p_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !p_valid_ff || commit;
   assign req_fire  = req_valid && req_ready;
   assign md        = byp_ff ? byp_data_ff : rd_data_ff;

   logic hit_pc0, hit_dc0, win_pc0, win_dc0, win_pc1;
   assign win_pc0 = in_win(pc0_ff, win_start_ff, win_end_ff, win_en_ff);
   assign win_dc0 = in_win(dc0_ff, win_start_ff, win_end_ff, win_en_ff);
   assign win_pc1 = in_win(pc1_ff, win_start_ff, win_end_ff, win_en_ff);
   assign hit_pc0 = win_pc0 && off_ok(pc0_ff, win_start_ff);
   assign hit_dc0 = win_dc0 && off_ok(dc0_ff, win_start_ff);

   always_comb begin
      bus_in   = p_item_ff.bus_in;
      drove_in = 1'b0;
      pc0_in   = pc0_ff;
      pc1_in   = pc1_ff;
      dc0_in   = dc0_ff;
      dc1_in   = dc1_ff;
      if (p_valid_ff && p_item_ff.operation == OP_ROMC) begin
         unique case (p_item_ff.romc_code)
            ROMC_FETCH_PC0, ROMC_FETCH_PC0_ALT: begin
               if (hit_pc0) begin bus_in = md; drove_in = 1'b1; end
               pc0_in = addr_type'(pc0_ff + 1'b1);
            end
            ROMC_BRANCH_PC0: begin
               if (!absent_ff[NO_PC0] && hit_pc0) begin bus_in = md; drove_in = 1'b1; end
               pc0_in = add_signed(pc0_ff, bus_in);
            end
            ROMC_FETCH_DC0: begin
               if (!absent_ff[NO_DC0]) begin
                  if (hit_dc0) begin bus_in = md; drove_in = 1'b1; end
                  dc0_in = addr_type'(dc0_ff + 1'b1);
               end
            end
            ROMC_PC1_TO_PC0: pc0_in = pc1_ff;
            ROMC_STORE_DC0: begin
               if (!absent_ff[NO_DC0]) dc0_in = addr_type'(dc0_ff + 1'b1);
            end
            ROMC_DRIVE_DC0_HIGH: begin
               bus_in = dc0_ff[ADDR_W-1:BYTE_W]; drove_in = 1'b1;
            end
            ROMC_DRIVE_PC1_HIGH: begin
               bus_in = pc1_ff[ADDR_W-1:BYTE_W]; drove_in = 1'b1;
            end
            ROMC_CLEAR_PC0: begin
               bus_in = '0;
               pc1_in = pc0_ff;
               pc0_in = '0;
            end
            ROMC_DRIVE_DC0_LOW: begin
               if (win_dc0) begin bus_in = dc0_ff[BYTE_W-1:0]; drove_in = 1'b1; end
            end
            ROMC_ADD_DC0: dc0_in = add_signed(dc0_ff, bus_in);
            ROMC_DRIVE_PC1_LOW: begin
               if (win_pc1) begin bus_in = pc1_ff[BYTE_W-1:0]; drove_in = 1'b1; end
            end
            ROMC_MEM_PC0_LOW: begin
               if (hit_pc0) begin bus_in = md; drove_in = 1'b1; end
               pc0_in = set_low(pc0_ff, bus_in);
            end
            ROMC_PC0_INC_TO_PC1: pc1_in = addr_type'(pc0_ff + 1'b1);
            ROMC_MEM_DC0_LOW: begin
               if (hit_pc0) begin bus_in = md; drove_in = 1'b1; end
               dc0_in = set_low(dc0_ff, bus_in);
            end
            ROMC_VECTOR, ROMC_CALL_LOW: begin
               pc1_in = pc0_ff;
               pc0_in = set_low(pc0_ff, bus_in);
            end
            ROMC_MEM_DC0_HIGH: begin
               if (hit_pc0) begin bus_in = md; drove_in = 1'b1; end
               dc0_in = set_high(dc0_ff, bus_in);
            end
            ROMC_BUS_PC0_HIGH: if (!absent_ff[NO_PC0]) pc0_in = set_high(pc0_ff, bus_in);
            ROMC_BUS_PC1_HIGH: if (!absent_ff[NO_PC1]) pc1_in = set_high(pc1_ff, bus_in);
            ROMC_BUS_DC0_HIGH: if (!absent_ff[NO_DC0]) dc0_in = set_high(dc0_ff, bus_in);
            ROMC_BUS_PC0_LOW:  if (!absent_ff[NO_PC0]) pc0_in = set_low(pc0_ff, bus_in);
            ROMC_BUS_PC1_LOW:  if (!absent_ff[NO_PC1]) pc1_in = set_low(pc1_ff, bus_in);
            ROMC_BUS_DC0_LOW:  if (!absent_ff[NO_DC0]) dc0_in = set_low(dc0_ff, bus_in);
            ROMC_SWAP_DC: begin
               if (!absent_ff[NO_DC1]) begin
                  dc0_in = dc1_ff;
                  dc1_in = dc0_ff;
               end
            end
            ROMC_DRIVE_PC0_LOW: begin
               if (!absent_ff[NO_PC1] && win_pc0) begin
                  bus_in = pc0_ff[BYTE_W-1:0]; drove_in = 1'b1;
               end
            end
            ROMC_DRIVE_PC0_HIGH: begin
               if (!absent_ff[NO_PC0] && win_pc0) begin
                  bus_in = pc0_ff[ADDR_W-1:BYTE_W]; drove_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // memory write at commit, read at accept with post-commit addresses
   always_comb begin
      la_ext  = CMP_W'(p_item_ff.load_address);
      wr_off  = addr_type'(dc0_ff - win_start_ff);
      wr_en   = 1'b0;
      wr_idx  = wr_off[AW-1:0];
      wr_data = p_item_ff.bus_in;
      if (p_item_ff.operation == OP_PRELOAD) begin
         wr_en   = commit && (la_ext < DEPTH_C);
         wr_idx  = la_ext[AW-1:0];
         wr_data = p_item_ff.load_data;
      end else if (p_item_ff.romc_code == ROMC_STORE_DC0) begin
         wr_en = commit && !absent_ff[NO_DC0] && hit_dc0 && writable_ff;
      end
   end

   assign rd_addr = (req_romc_code == ROMC_FETCH_DC0) ? dc0_in : pc0_in;
   assign rd_off  = addr_type'(rd_addr - win_start_ff);
   assign rd_idx  = rd_off[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      if (req_fire) begin
         rd_data_ff  <= mem[rd_idx];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         pc0_ff       <= '0;
         pc1_ff       <= '0;
         dc0_ff       <= '0;
         dc1_ff       <= '0;
      end else begin
         if (req_fire) begin
            p_valid_ff <= 1'b1;
            byp_ff     <= wr_en && (wr_idx == rd_idx);
         end else if (commit) begin
            p_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            pc0_ff <= pc0_in;
            pc1_ff <= pc1_in;
            dc0_ff <= dc0_in;
            dc1_ff <= dc1_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_item_ff <= '{operation:    req_operation,
                        romc_code:    req_romc_code,
                        bus_in:       req_bus_in,
                        load_address: req_load_address,
                        load_data:    req_load_data};
      end
      if (commit) begin
         rsp_bus_ff   <= bus_in;
         rsp_drove_ff <= drove_in;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_bus_out                = rsp_bus_ff;
   assign rsp_drove_bus              = rsp_drove_ff;
   assign rsp_program_counter        = pc0_ff;
   assign rsp_stack_register         = pc1_ff;
   assign rsp_data_counter           = dc0_ff;
   assign rsp_alternate_data_counter = dc1_ff;

   a_regs_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pc0_ff) && $stable(dc0_ff) && $stable(pc1_ff))
      else $error("address registers moved under a stalled result");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("beat taken while work stage is blocked");

   a_write_on_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> commit)
      else $error("memory written without a commit");

   a_clear_no_drive: assert property (@(posedge clock) disable iff (reset)
      commit && p_item_ff.operation == OP_ROMC && p_item_ff.romc_code == ROMC_CLEAR_PC0
      |=> !rsp_drove_bus && rsp_bus_out == '0 && pc0_ff == '0)
      else $error("clear cycle drove the bus or left PC0 set");

endmodule
